FILE: rtl/spof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spof_pkg;

    localparam int MAX_LEN   = 256;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int SYM_W     = 8;
    localparam int CLIP_W    = 9;
    localparam int COUNT_W   = 16;
    localparam int MINOV_W   = 9;
    localparam int RATE_W    = 17;
    localparam int OFFSET_W  = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;
    localparam int TRY_W     = 10;
    localparam int SUM_W     = COUNT_W + 3;
    localparam int PROD_W    = 27;
    localparam int NUM_W     = 29;
    localparam int NC_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OVERLAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_RATE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_LEN,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/spof_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spof_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [spof_pkg::SYM_W-1:0]    base;
    logic                          last;
    logic [spof_pkg::CLIP_W-1:0]   local_clip;
    logic [spof_pkg::COUNT_W-1:0]  clip_count;

    modport source (
        output valid, cmd, base, last, local_clip, clip_count,
        input  ready
    );
    modport sink (
        input  valid, cmd, base, last, local_clip, clip_count,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/spof_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spof_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [spof_pkg::LEN_W-1:0]          overlap_length;
    logic [spof_pkg::LEN_W-1:0]          mismatches;
    logic signed [spof_pkg::OFFSET_W-1:0] clipped_offset;

    modport source (
        output valid, found, overlap_length, mismatches, clipped_offset,
        input  ready
    );
    modport sink (
        input  valid, found, overlap_length, mismatches, clipped_offset,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/spof_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module spof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/suffix_prefix_overlap_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat contents                                        Rate
// i_item    in   cmd, base, last, local_clip, clip_count              1 beat/cycle while idle
// o_result  out  found, overlap_length, mismatches, clipped_offset    1 beat per second sequence
// i_cfg_*   in   register index, write data                           1 write/cycle
//
// While idle, each symbol goes straight into its store, up to 256 symbols per sequence.
// The last beat of the second sequence starts the search: a setup state, then for
// each tried length L a state to form the limit and a compare state that reads
// one symbol pair per cycle from the two store read ports.
// Input is held off during the search and a closing state, which stretches while
// an earlier result still waits; a pending result alone does not block loading.
// Reset (synchronous, active low) clears state, lengths, fill counts, config and output valid.
module suffix_prefix_overlap_finder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    spof_in_if.sink                                i_item,
    spof_out_if.source                             o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [spof_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [spof_pkg::CFG_DAT_W-1:0]    i_cfg_wdata
);

    spof_pkg::t_state r_state, n_state;

    logic [spof_pkg::MINOV_W-1:0]  r_min_overlap;
    logic [spof_pkg::RATE_W-1:0]   r_rate;

    logic [spof_pkg::LEN_W-1:0]    r_fill1, r_fill2, n_fill1, n_fill2;
    logic [spof_pkg::LEN_W-1:0]    r_len1, r_len2;
    logic [spof_pkg::CLIP_W-1:0]   r_clip1, r_clip2;
    logic [spof_pkg::COUNT_W-1:0]  r_total1, r_total2;

    logic signed [spof_pkg::OFFSET_W-1:0] r_init, n_init;
    logic [spof_pkg::TRY_W-1:0]    r_try;
    logic [spof_pkg::LEN_W-1:0]    r_end;
    logic [spof_pkg::SUM_W-1:0]    r_sum;
    logic                          r_den_zero;
    logic [spof_pkg::NC_W-1:0]     r_nc;
    logic [spof_pkg::LEN_W-1:0]    r_k;
    logic                          r_rd_v;
    logic [spof_pkg::LEN_W-1:0]    r_cnt;
    logic [spof_pkg::PROD_W-1:0]   r_prod;
    logic                          r_found;

    logic                          r_out_valid;
    logic                          r_out_found;
    logic [spof_pkg::LEN_W-1:0]    r_out_len;
    logic [spof_pkg::LEN_W-1:0]    r_out_mis;
    logic signed [spof_pkg::OFFSET_W-1:0] r_out_off;

    logic                          accept;
    logic                          wr1, wr2;
    logic                          issue;
    logic                          out_load;
    logic                          fail;
    logic                          cmp_end;
    logic                          try_over;
    logic [spof_pkg::LEN_W-1:0]    cur_len;
    logic [spof_pkg::LEN_W-1:0]    raddr1_full;
    logic [spof_pkg::SYM_W-1:0]    rdata1, rdata2;
    logic [spof_pkg::COUNT_W-1:0]  lo, hi;
    logic [spof_pkg::TRY_W-1:0]    start;
    logic [25:0]                   lr_prod;
    logic [spof_pkg::NUM_W-1:0]    num;

    assign cur_len     = r_try[spof_pkg::LEN_W-1:0];
    assign accept      = i_item.valid && i_item.ready;
    assign wr1         = accept && !i_item.cmd && (r_fill1 < spof_pkg::LEN_W'(spof_pkg::MAX_LEN));
    assign wr2         = accept && i_item.cmd && (r_fill2 < spof_pkg::LEN_W'(spof_pkg::MAX_LEN));
    assign n_fill1     = r_fill1 + spof_pkg::LEN_W'(wr1);
    assign n_fill2     = r_fill2 + spof_pkg::LEN_W'(wr2);
    assign raddr1_full = r_len1 - cur_len + r_k;
    assign fail        = !r_den_zero && (r_cnt != '0)
                         && (r_prod >= spof_pkg::PROD_W'(r_nc));
    assign cmp_end     = (r_k == cur_len) && !r_rd_v;
    assign try_over    = r_try > spof_pkg::TRY_W'(r_end);

    assign n_init  = spof_pkg::OFFSET_W'(r_len1) - spof_pkg::OFFSET_W'(r_clip1)
                     + spof_pkg::OFFSET_W'(r_clip2);
    assign lo      = (r_total1 < r_total2) ? r_total1 : r_total2;
    assign hi      = (r_total1 < r_total2) ? r_total2 : r_total1;
    assign start   = (n_init > $signed(spof_pkg::OFFSET_W'(r_min_overlap)))
                     ? n_init[spof_pkg::TRY_W-1:0]
                     : spof_pkg::TRY_W'(r_min_overlap);
    assign lr_prod = cur_len * r_rate;
    assign num     = (spof_pkg::NUM_W'(lr_prod) << 2) + spof_pkg::NUM_W'(lr_prod)
                     + spof_pkg::NUM_W'(16'hFFFF);

    spof_ram #(.WIDTH(spof_pkg::SYM_W), .DEPTH(spof_pkg::MAX_LEN)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (wr1),
        .i_waddr (r_fill1[spof_pkg::ADDR_W-1:0]),
        .i_wdata (i_item.base),
        .i_raddr (raddr1_full[spof_pkg::ADDR_W-1:0]),
        .o_rdata (rdata1)
    );

    spof_ram #(.WIDTH(spof_pkg::SYM_W), .DEPTH(spof_pkg::MAX_LEN)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (wr2),
        .i_waddr (r_fill2[spof_pkg::ADDR_W-1:0]),
        .i_wdata (i_item.base),
        .i_raddr (r_k[spof_pkg::ADDR_W-1:0]),
        .o_rdata (rdata2)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spof_pkg::ST_IDLE: begin
                if (accept && i_item.cmd && i_item.last) begin
                    n_state = spof_pkg::ST_INIT;
                end
            end
            spof_pkg::ST_INIT: begin
                n_state = spof_pkg::ST_LEN;
            end
            spof_pkg::ST_LEN: begin
                n_state = try_over ? spof_pkg::ST_DONE : spof_pkg::ST_CMP;
            end
            spof_pkg::ST_CMP: begin
                if (fail) begin
                    n_state = spof_pkg::ST_LEN;
                end else if (cmp_end) begin
                    n_state = spof_pkg::ST_DONE;
                end
            end
            spof_pkg::ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = spof_pkg::ST_IDLE;
                end
            end
            default: n_state = spof_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_item.ready = 1'b0;
        issue        = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            spof_pkg::ST_IDLE: i_item.ready = 1'b1;
            spof_pkg::ST_CMP:  issue = r_k < cur_len;
            spof_pkg::ST_DONE: out_load = !r_out_valid || o_result.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= spof_pkg::ST_IDLE;
            r_min_overlap <= '0;
            r_rate        <= '0;
            r_fill1       <= '0;
            r_fill2       <= '0;
            r_len1        <= '0;
            r_len2        <= '0;
            r_clip1       <= '0;
            r_total1      <= '0;
            r_out_valid   <= 1'b0;
            r_rd_v        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spof_pkg::CFG_MIN_OVERLAP:
                        r_min_overlap <= i_cfg_wdata[spof_pkg::MINOV_W-1:0];
                    spof_pkg::CFG_MISMATCH_RATE:
                        r_rate <= i_cfg_wdata[spof_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end

            if (accept && !i_item.cmd) begin
                if (i_item.last) begin
                    r_len1   <= n_fill1;
                    r_fill1  <= '0;
                    r_clip1  <= i_item.local_clip;
                    r_total1 <= i_item.clip_count;
                end else begin
                    r_fill1 <= n_fill1;
                end
            end
            if (accept && i_item.cmd) begin
                if (i_item.last) begin
                    r_len2  <= n_fill2;
                    r_fill2 <= '0;
                end else begin
                    r_fill2 <= n_fill2;
                end
            end

            r_rd_v <= issue;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // search datapath and result registers
    always_ff @(posedge i_clk) begin
        if (accept && i_item.cmd && i_item.last) begin
            r_clip2  <= i_item.local_clip;
            r_total2 <= i_item.clip_count;
        end

        if (r_state == spof_pkg::ST_INIT) begin
            r_init     <= n_init;
            r_try      <= start;
            r_end      <= (r_len1 < r_len2) ? r_len1 : r_len2;
            r_sum      <= (spof_pkg::SUM_W'(lo) << 2) + spof_pkg::SUM_W'(hi);
            r_den_zero <= (lo == '0) && (hi == '0);
        end

        if (r_state == spof_pkg::ST_LEN) begin
            r_nc    <= num[spof_pkg::NC_W+15:16];
            r_k     <= '0;
            r_cnt   <= '0;
            r_prod  <= '0;
            r_found <= 1'b0;
        end

        if (r_state == spof_pkg::ST_CMP) begin
            if (issue) begin
                r_k <= r_k + 1'b1;
            end
            if (r_rd_v && (rdata1 != rdata2)) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    r_prod <= r_prod + spof_pkg::PROD_W'(r_sum);
                end
            end
            if (fail) begin
                r_try <= r_try + 1'b1;
            end else if (cmp_end) begin
                r_found <= 1'b1;
            end
        end

        if (out_load) begin
            r_out_found <= r_found;
            r_out_len   <= r_found ? cur_len : '0;
            r_out_mis   <= r_found ? r_cnt : '0;
            r_out_off   <= r_found ? (spof_pkg::OFFSET_W'(cur_len) - r_init) : '0;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.found          = r_out_found;
    assign o_result.overlap_length = r_out_len;
    assign o_result.mismatches     = r_out_mis;
    assign o_result.clipped_offset = r_out_off;

endmodule
`default_nettype wire
